>>> design/owdm_pkg.sv
// ----------------------------------------------------------------------------
// owdm_pkg: shared types, constants and tables for the omni wheel drive mixer
// Holds field widths, the Q1.15 cosine table, item structs and small helpers.
// ----------------------------------------------------------------------------
package owdm_pkg;

  localparam int DRIVE_LIMIT       = 255;
  localparam int COS_FRACTION_BITS = 15;

  localparam int FIELD_W = 9;                      // I/O field width
  localparam int SPD_W   = FIELD_W - 1;            // clamped speed magnitude
  localparam int V_W     = FIELD_W + 1;            // first pass sum, signed
  localparam int MAG_W   = FIELD_W;                // first pass sum magnitude
  localparam int COS_W   = COS_FRACTION_BITS + 1;  // cosine magnitude
  localparam int DEN_W   = COS_W + 1;              // doubled divisor
  localparam int NUM_W   = COS_W + FIELD_W + 1;    // rounding numerator
  localparam int QW      = FIELD_W;                // quotient magnitude bits
  localparam int DIV_W   = NUM_W + DEN_W;          // compare width in divider
  localparam int LANES   = 4;
  localparam int ANG_W   = 10;
  localparam int IDX_W   = 7;
  localparam int COS_ENTRIES = 91;
  localparam int COS_SHIFT   = 30 - COS_FRACTION_BITS;

  // Mount angle per lane, lane order: back right, front right, back left, front left
  localparam int MOUNT_DEG [LANES] = '{135, 225, 45, 315};

  localparam logic [63:0] DEG_TO_RAD_Q30 = 64'd18740330;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182, 64'd240};

  typedef logic [COS_W-1:0] cos_tab_t [COS_ENTRIES];

  // cos(k deg) for k = 0..90: Taylor series through x^16 in Q30, then rounded
  function automatic cos_tab_t build_cos_table();
    cos_tab_t          t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        c;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      x    = 64'(k) * DEG_TO_RAD_Q30;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
        if ((n & 1) == 1) sum = sum - signed'(term);
        else              sum = sum + signed'(term);
      end
      if (sum < 0) sum = '0;
      c = unsigned'(sum);
      if (COS_SHIFT > 0) c = (c + (64'd1 << (COS_SHIFT - 1))) >> COS_SHIFT;
      t[k] = COS_W'(c);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TABLE = build_cos_table();

  typedef struct packed {
    logic signed [FIELD_W-1:0] rot;
    logic signed [FIELD_W-1:0] spd;
    logic                      zero;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QW-1:0]    quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [LANES-1:0] lane;
    logic [DEN_W-1:0]      den;
    side_t                 side;
  } div_item_t;

  // Clamp to the drive limit
  function automatic logic signed [FIELD_W-1:0] clamp_drive(logic signed [FIELD_W-1:0] v);
    int e;
    e = int'(v);
    if (e > DRIVE_LIMIT)  e = DRIVE_LIMIT;
    if (e < -DRIVE_LIMIT) e = -DRIVE_LIMIT;
    return FIELD_W'(e);
  endfunction

  // Magnitude of a clamped drive value
  function automatic logic [SPD_W-1:0] drive_mag(logic signed [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] t;
    t = v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
    return t[SPD_W-1:0];
  endfunction

endpackage

>>> design/owdm_cmd_if.sv
// ----------------------------------------------------------------------------
// owdm_cmd_if: drive command channel
// Valid/ready channel carrying heading, rotation and speed.
// ----------------------------------------------------------------------------
interface owdm_cmd_if;
  logic                valid;
  logic                ready;
  logic [8:0]          heading_deg;
  logic signed [8:0]   turn_rate;
  logic signed [8:0]   drive_speed;

  modport source (output valid, heading_deg, turn_rate, drive_speed, input ready);
  modport sink   (input valid, heading_deg, turn_rate, drive_speed, output ready);
endinterface

>>> design/owdm_wheel_if.sv
// ----------------------------------------------------------------------------
// owdm_wheel_if: wheel drive result channel
// Valid/ready channel carrying the four signed wheel drive values.
// ----------------------------------------------------------------------------
interface owdm_wheel_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] wheel_front_right;
  logic signed [8:0] wheel_front_left;
  logic signed [8:0] wheel_back_right;
  logic signed [8:0] wheel_back_left;

  modport source (output valid, wheel_front_right, wheel_front_left,
                  wheel_back_right, wheel_back_left, input ready);
  modport sink   (input valid, wheel_front_right, wheel_front_left,
                  wheel_back_right, wheel_back_left, output ready);
endinterface

>>> design/owdm_weight.sv
// ----------------------------------------------------------------------------
// owdm_weight: wheel weight front end
// Five stages: input clamp, angle fold, cosine lookup, max, first pass numerator.
// ----------------------------------------------------------------------------
module owdm_weight (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [owdm_pkg::FIELD_W-1:0]        heading_deg,
  input  logic signed [owdm_pkg::FIELD_W-1:0] turn_rate,
  input  logic signed [owdm_pkg::FIELD_W-1:0] drive_speed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output owdm_pkg::div_item_t                 out_item
);
  import owdm_pkg::*;

  logic [4:0] v;
  logic [5:0] en;

  logic [FIELD_W-1:0] s0_h;
  side_t              s0_side;
  logic [IDX_W-1:0]   s1_k [LANES];
  logic [LANES-1:0]   s1_neg;
  side_t              s1_side;
  logic [COS_W-1:0]   s2_mag [LANES];
  logic [LANES-1:0]   s2_neg;
  side_t              s2_side;
  logic [COS_W-1:0]   s3_mag [LANES];
  logic [COS_W-1:0]   s3_m;
  logic [LANES-1:0]   s3_neg;
  side_t              s3_side;

  logic [FIELD_W-1:0] h_next;
  side_t              side_next;
  logic [IDX_W-1:0]   k_next [LANES];
  logic [LANES-1:0]   fneg_next;
  logic [COS_W-1:0]   m_next;
  div_item_t          item_next;

  // Stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    en[5] = out_ready;
    for (int s = 4; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v[4];

  // Stage 0: heading modulo 360, clamps
  always_comb begin
    h_next         = (heading_deg >= FIELD_W'(360)) ? heading_deg - FIELD_W'(360) : heading_deg;
    side_next.rot  = clamp_drive(turn_rate);
    side_next.spd  = clamp_drive(drive_speed);
    side_next.zero = (drive_speed == '0);
  end

  // Stage 1: wheel angle and quadrant fold
  always_comb begin
    logic [ANG_W-1:0] a;
    for (int l = 0; l < LANES; l++) begin
      a = ANG_W'(s0_h) + ANG_W'(MOUNT_DEG[l]);
      if (a >= ANG_W'(360)) a = a - ANG_W'(360);
      if (a <= ANG_W'(90)) begin
        k_next[l] = IDX_W'(a);                fneg_next[l] = 1'b0;
      end else if (a <= ANG_W'(180)) begin
        k_next[l] = IDX_W'(ANG_W'(180) - a);  fneg_next[l] = 1'b1;
      end else if (a <= ANG_W'(270)) begin
        k_next[l] = IDX_W'(a - ANG_W'(180));  fneg_next[l] = 1'b1;
      end else begin
        k_next[l] = IDX_W'(ANG_W'(360) - a);  fneg_next[l] = 1'b0;
      end
    end
  end

  // Stage 3: largest weight magnitude
  always_comb begin
    m_next = '0;
    for (int l = 0; l < LANES; l++) if (s2_mag[l] > m_next) m_next = s2_mag[l];
  end

  // Stage 4: numerator 2*|w*spd| + m and divisor 2*m
  always_comb begin
    logic [NUM_W-1:0] prod;
    item_next.den  = DEN_W'(s3_m) << 1;
    item_next.side = s3_side;
    for (int l = 0; l < LANES; l++) begin
      prod = NUM_W'(s3_mag[l]) * NUM_W'(drive_mag(s3_side.spd));
      item_next.lane[l].rem = (prod << 1) + NUM_W'(s3_m);
      item_next.lane[l].quo = '0;
      item_next.lane[l].neg = s3_neg[l] ^ s3_side.spd[FIELD_W-1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < 5; s++) if (en[s]) v[s] <= v[s-1];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_h    <= h_next;
      s0_side <= side_next;
    end
    if (en[1]) begin
      s1_k    <= k_next;
      s1_neg  <= fneg_next;
      s1_side <= s0_side;
    end
    if (en[2]) begin
      for (int l = 0; l < LANES; l++) s2_mag[l] <= COS_TABLE[s1_k[l]];
      s2_neg  <= s1_neg;
      s2_side <= s1_side;
    end
    if (en[3]) begin
      s3_mag  <= s2_mag;
      s3_m    <= m_next;
      s3_neg  <= s2_neg;
      s3_side <= s2_side;
    end
    if (en[4]) out_item <= item_next;
  end

endmodule

>>> design/owdm_rdiv.sv
// ----------------------------------------------------------------------------
// owdm_rdiv: pipelined restoring divider, four lanes with a shared divisor
// One quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module owdm_rdiv (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  owdm_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output owdm_pkg::div_item_t out_item
);
  import owdm_pkg::*;

  div_item_t  feed [QW+1];
  logic [QW:0] feed_v;
  logic [QW:0] en;

  assign feed[0]   = in_item;
  assign feed_v[0] = in_valid;
  assign en[QW]    = out_ready;
  assign in_ready  = en[0];
  assign out_valid = feed_v[QW];
  assign out_item  = feed[QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int J = QW - 1 - s;
    div_item_t nxt;
    div_item_t stg;
    logic      v;

    assign en[s] = !v || en[s+1];

    // Trial subtract of the divisor at bit J
    always_comb begin
      logic [DIV_W-1:0] r_ext;
      logic [DIV_W-1:0] d_ext;
      nxt   = feed[s];
      d_ext = DIV_W'(feed[s].den) << J;
      for (int l = 0; l < LANES; l++) begin
        r_ext = DIV_W'(feed[s].lane[l].rem);
        if (r_ext >= d_ext) begin
          nxt.lane[l].rem    = NUM_W'(r_ext - d_ext);
          nxt.lane[l].quo[J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v <= 1'b0;
      else if (en[s]) v <= feed_v[s];
    end

    always_ff @(posedge clk) begin
      if (en[s]) stg <= nxt;
    end

    assign feed[s+1]   = stg;
    assign feed_v[s+1] = v;
  end

endmodule

>>> design/owdm_mix.sv
// ----------------------------------------------------------------------------
// owdm_mix: rotation mix between the two scaling passes
// Four stages: add rotation, magnitude, max, second pass numerator.
// ----------------------------------------------------------------------------
module owdm_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  owdm_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output owdm_pkg::div_item_t out_item
);
  import owdm_pkg::*;

  logic [3:0] v;
  logic [4:0] en;

  logic signed [V_W-1:0] t0_v [LANES];
  side_t                 t0_side;
  logic [MAG_W-1:0]      t1_mag [LANES];
  logic [LANES-1:0]      t1_neg;
  side_t                 t1_side;
  logic [MAG_W-1:0]      t2_mag [LANES];
  logic [MAG_W-1:0]      t2_m;
  logic [LANES-1:0]      t2_neg;
  side_t                 t2_side;

  logic signed [V_W-1:0] v_next [LANES];
  logic [MAG_W-1:0]      mag_next [LANES];
  logic [LANES-1:0]      neg_next;
  logic [MAG_W-1:0]      m_next;
  div_item_t             item_next;

  always_comb begin
    en[4] = out_ready;
    for (int s = 3; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v[3];

  // Signed first pass quotient plus rotation
  always_comb begin
    logic signed [V_W-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = signed'(V_W'(in_item.lane[l].quo));
      if (in_item.lane[l].neg) q = -q;
      v_next[l] = q + V_W'(in_item.side.rot);
    end
  end

  // Magnitude and result sign
  always_comb begin
    logic [V_W-1:0] a;
    for (int l = 0; l < LANES; l++) begin
      a = t0_v[l][V_W-1] ? V_W'(-t0_v[l]) : V_W'(t0_v[l]);
      mag_next[l] = a[MAG_W-1:0];
      neg_next[l] = t0_v[l][V_W-1] ^ t0_side.spd[FIELD_W-1];
    end
  end

  // Largest magnitude
  always_comb begin
    m_next = '0;
    for (int l = 0; l < LANES; l++) if (t1_mag[l] > m_next) m_next = t1_mag[l];
  end

  // Numerator 2*|v*spd| + m and divisor 2*m
  always_comb begin
    logic [NUM_W-1:0] prod;
    item_next.den  = DEN_W'(t2_m) << 1;
    item_next.side = t2_side;
    for (int l = 0; l < LANES; l++) begin
      prod = NUM_W'(t2_mag[l]) * NUM_W'(drive_mag(t2_side.spd));
      item_next.lane[l].rem = (prod << 1) + NUM_W'(t2_m);
      item_next.lane[l].quo = '0;
      item_next.lane[l].neg = t2_neg[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < 4; s++) if (en[s]) v[s] <= v[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_v    <= v_next;
      t0_side <= in_item.side;
    end
    if (en[1]) begin
      t1_mag  <= mag_next;
      t1_neg  <= neg_next;
      t1_side <= t0_side;
    end
    if (en[2]) begin
      t2_mag  <= t1_mag;
      t2_m    <= m_next;
      t2_neg  <= t1_neg;
      t2_side <= t1_side;
    end
    if (en[3]) out_item <= item_next;
  end

endmodule

>>> design/omni_wheel_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer_top: four wheel omni drive mixer
// Heading, rotation and speed in; four signed wheel drive values out.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   heading_deg, turn_rate, drive_speed
//   wheel    out  valid/ready   wheel_front_right/left, wheel_back_right/left
//
// One item per cycle while the wheel side takes results; the pipe is the two 9-stage
// restoring dividers plus 5 front-end, 4 mix and 1 output stage.
// Reset clears only valid bits.
// Each stage holds while the stage after it is full and stalled; empty stages
// fill, so a stall at the output loses and repeats nothing.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer_top (
  input  logic              clk,
  input  logic              rst,
  owdm_cmd_if.sink          cmd,
  owdm_wheel_if.source      wheel
);
  import owdm_pkg::*;

  logic      w_valid, w_ready;
  div_item_t w_item;
  logic      d1_valid, d1_ready;
  div_item_t d1_item;
  logic      m_valid, m_ready;
  div_item_t m_item;
  logic      d2_valid, d2_ready;
  div_item_t d2_item;

  logic                      out_v;
  logic                      out_zero;
  logic signed [FIELD_W-1:0] res [LANES];
  logic signed [FIELD_W-1:0] res_next [LANES];
  logic                      en_out;

  owdm_weight u_weight (
    .clk(clk), .rst(rst),
    .in_valid(cmd.valid), .in_ready(cmd.ready),
    .heading_deg(cmd.heading_deg), .turn_rate(cmd.turn_rate),
    .drive_speed(cmd.drive_speed),
    .out_valid(w_valid), .out_ready(w_ready), .out_item(w_item)
  );

  owdm_rdiv u_div1 (
    .clk(clk), .rst(rst),
    .in_valid(w_valid), .in_ready(w_ready), .in_item(w_item),
    .out_valid(d1_valid), .out_ready(d1_ready), .out_item(d1_item)
  );

  owdm_mix u_mix (
    .clk(clk), .rst(rst),
    .in_valid(d1_valid), .in_ready(d1_ready), .in_item(d1_item),
    .out_valid(m_valid), .out_ready(m_ready), .out_item(m_item)
  );

  owdm_rdiv u_div2 (
    .clk(clk), .rst(rst),
    .in_valid(m_valid), .in_ready(m_ready), .in_item(m_item),
    .out_valid(d2_valid), .out_ready(d2_ready), .out_item(d2_item)
  );

  // Output register: apply sign, or pure rotation when speed is zero
  assign en_out   = !out_v || wheel.ready;
  assign d2_ready = en_out;

  always_comb begin
    logic signed [V_W-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = signed'(V_W'(d2_item.lane[l].quo));
      if (d2_item.lane[l].neg) q = -q;
      res_next[l] = d2_item.side.zero ? d2_item.side.rot : FIELD_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en_out) out_v <= d2_valid;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res      <= res_next;
      out_zero <= d2_item.side.zero;
    end
  end

  assign wheel.valid             = out_v;
  assign wheel.wheel_back_right  = res[0];
  assign wheel.wheel_front_right = res[1];
  assign wheel.wheel_back_left   = res[2];
  assign wheel.wheel_front_left  = res[3];

  // Pure rotation gives the same value on all wheels
  a_rot_equal: assert property (@(posedge clk) disable iff (rst)
    out_v && out_zero |-> res[0] == res[1] && res[1] == res[2] && res[2] == res[3])
    else $error("pure rotation wheels differ");

  // Outputs stay within the drive limit
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> res[0] != -256 && res[1] != -256 && res[2] != -256 && res[3] != -256)
    else $error("wheel value beyond limit");

  // Input only stalls when the whole pipe is backed up at the output
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> out_v && !wheel.ready)
    else $error("input stalled without output stall");

endmodule

>>> sim/tb_omni_wheel_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// tb_omni_wheel_drive_mixer_top: testbench for the omni wheel drive mixer
// Random and directed drive commands go in on the command channel. Each item
// is predicted by an integer model of the two scaling passes, and the four
// wheel values of every result are compared in order. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_omni_wheel_drive_mixer_top;
  import owdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic signed [8:0] fr;
    logic signed [8:0] fl;
    logic signed [8:0] br;
    logic signed [8:0] bl;
  } wheels_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  owdm_cmd_if   cmd ();
  owdm_wheel_if wheel ();

  omni_wheel_drive_mixer_top DUT (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd.sink),
    .wheel (wheel.source)
  );

  always #1 clk = ~clk;

  wheels_t expected_wheels[$];
  int      errors      = 0;
  int      idle_count  = 0;
  bit      no_idle     = 1'b0;
  bit      hold_off    = 1'b0;
  bit      hold_seen   = 1'b0;
  longint  cos_q15 [91];

  // Cosine table, Taylor series in Q30 then rounded to Q15
  initial begin
    longint unsigned x, x2, term, c;
    longint sum;
    for (int k = 0; k <= 90; k++) begin
      x = longint'(k) * 18740330;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      c = (longint'(sum) + (64'd1 << 14)) >> 15;
      cos_q15[k] = longint'(c);
    end
  end

  function automatic longint cos_of(int d);
    d = d % 360;
    if (d <= 90) return cos_q15[d];
    if (d <= 180) return -cos_q15[180 - d];
    if (d <= 270) return -cos_q15[d - 180];
    return cos_q15[360 - d];
  endfunction

  // Half away from zero, den > 0
  function automatic longint div_round(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint lim(logic signed [8:0] v);
    longint e;
    e = longint'(v);
    if (e > DRIVE_LIMIT) e = DRIVE_LIMIT;
    if (e < -DRIVE_LIMIT) e = -DRIVE_LIMIT;
    return e;
  endfunction

  // Wheel values for one command; lanes are mounts 135, 225, 45, 315
  function automatic wheels_t mix_wheels(logic [8:0] hd, logic signed [8:0] tr,
                                         logic signed [8:0] sp);
    int mounts [4] = '{135, 225, 45, 315};
    longint w [4];
    longint rot, spd, m, a;
    wheels_t r;
    rot = lim(tr);
    spd = lim(sp);
    if (spd == 0) begin
      for (int i = 0; i < 4; i++) w[i] = rot;
    end else begin
      m = 0;
      for (int i = 0; i < 4; i++) begin
        w[i] = cos_of(mounts[i] + int'(hd) % 360);
        a = (w[i] < 0) ? -w[i] : w[i];
        if (a > m) m = a;
      end
      if (m == 0) m = 1;
      for (int i = 0; i < 4; i++) w[i] = div_round(w[i] * spd, m) + rot;
      m = 0;
      for (int i = 0; i < 4; i++) begin
        a = (w[i] < 0) ? -w[i] : w[i];
        if (a > m) m = a;
      end
      for (int i = 0; i < 4; i++) w[i] = (m == 0) ? 0 : div_round(w[i] * spd, m);
    end
    r.fr = 9'(w[1]);
    r.fl = 9'(w[3]);
    r.br = 9'(w[0]);
    r.bl = 9'(w[2]);
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 23);
  endfunction

  // Send one command and wait for its acceptance; valid drops only while idling
  task automatic send_cmd(logic [8:0] hd, logic signed [8:0] tr, logic signed [8:0] sp);
    while (idle_now()) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.heading_deg <= hd;
    cmd.turn_rate   <= tr;
    cmd.drive_speed <= sp;
    do @(posedge clk); while (!cmd.ready);
    expected_wheels.push_back(mix_wheels(hd, tr, sp));
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [8:0] vals [6] = '{9'sd0, 9'sd1, -9'sd1, 9'sd255, -9'sd255, -9'sd256};
    send_cmd(9'd0, 9'sd0, 9'sd255);
    send_cmd(9'd90, 9'sd255, 9'sd255);
    send_cmd(9'd180, -9'sd256, -9'sd256);
    send_cmd(9'd359, -9'sd255, 9'sd1);
    send_cmd(9'd360, 9'sd10, 9'sd100);
    send_cmd(9'd511, 9'sd0, -9'sd1);
    send_cmd(9'd45, 9'sd255, 9'sd0);
    send_cmd(9'd270, -9'sd256, 9'sd0);
    send_cmd(9'd0, 9'sd0, 9'sd0);
    foreach (vals[i]) send_cmd(9'(i * 67), vals[i], vals[5 - i]);
    send_cmd(9'd135, 9'sd100, -9'sd200);
    send_cmd(9'd225, -9'sd128, 9'sd128);
  endtask

  task automatic test_random(int count);
    logic [8:0] hd;
    for (int n = 0; n < count; n++) begin
      hd = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(359));
      send_cmd(hd, 9'($urandom), ($urandom_range(15) == 0) ? 9'sd0 : 9'($urandom));
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall(int count);
    hold_off = 1'b1;
    test_random(count);
  endtask

  // Receiver side
  always @(negedge clk) begin
    int hold;
    if (rst) begin
      wheel.ready <= 1'b0;
    end else if (hold_off && !hold_seen) begin
      wheel.ready <= 1'b0;
      for (hold = 0; hold < 200; hold++) @(negedge clk);
      hold_seen = 1'b1;
      wheel.ready <= 1'b1;
    end else begin
      wheel.ready <= !idle_now();
    end
  end

  // Result check
  always @(posedge clk) begin
    wheels_t got, exp_w;
    if (!rst && wheel.valid && wheel.ready) begin
      got = '{wheel.wheel_front_right, wheel.wheel_front_left,
              wheel.wheel_back_right, wheel.wheel_back_left};
      if (expected_wheels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_w = expected_wheels.pop_front();
        if (got !== exp_w) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_w, got);
        end
      end
    end
  end

  // Watchdog on cycles with no acceptance
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (wheel.valid && wheel.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd.valid       <= 1'b0;
    cmd.heading_deg <= '0;
    cmd.turn_rate   <= '0;
    cmd.drive_speed <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(700);
    test_back_to_back(400);
    test_output_stall(150);
    test_random(580);
    cmd.valid <= 1'b0;
    while (expected_wheels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
